[src/mbsweep_pkg.sv]
// shared constants, register codes and types of the mark bitmap sweeper
`timescale 1ns / 1ps
`default_nettype none
package mbsweep_pkg;

  localparam int MARK_WORD_BITS = 64;
  localparam int MAX_SLOTS      = 65536;
  localparam int ADDR_W         = 48;
  localparam int SIZE_W         = 16;
  localparam int COUNT_W        = 17;
  localparam int BYTES_W        = 32;
  localparam int WIDX_W         = 10;
  localparam int MWC_W          = 11;
  localparam int NV_W           = 7;
  localparam int OFF_W          = 32;
  localparam int PADDR_W        = 5;
  localparam int PDATA_W        = 64;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = 1;
  localparam int QCNT_W         = 2;

  localparam logic [ADDR_W-1:0]  RST_REGION_BASE     = '0;
  localparam logic [SIZE_W-1:0]  RST_OBJECT_SIZE     = 16'd8;
  localparam logic [COUNT_W-1:0] RST_SLOT_COUNT      = 17'd65536;
  localparam logic [MWC_W-1:0]   RST_MARK_WORD_COUNT = 11'd1024;

  typedef enum logic [1:0] {
    REG_REGION_BASE     = 2'd0,
    REG_OBJECT_SIZE     = 2'd1,
    REG_SLOT_COUNT      = 2'd2,
    REG_MARK_WORD_COUNT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  region_base;
    logic [SIZE_W-1:0]  object_size;
    logic [COUNT_W-1:0] slot_count;
    logic [MWC_W-1:0]   mark_word_count;
  } cfg_t;

  // one classified mark word, as handed from front to back
  typedef struct packed {
    logic [MARK_WORD_BITS-1:0] free_mask;
    logic [NV_W-1:0]           nvalid;
    logic                      closing;
    logic [OFF_W-1:0]          off_start;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE    = 2'd0,
    BK_RUN     = 2'd1,
    BK_SUMMARY = 2'd2
  } bk_state_t;

endpackage
`default_nettype wire

[src/mbsweep_in_if.sv]
// mark word channel
`timescale 1ns / 1ps
`default_nettype none
interface mbsweep_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [mbsweep_pkg::MARK_WORD_BITS-1:0]  mark_word;

  modport source (output valid, output mark_word, input ready);
  modport sink   (input valid, input mark_word, output ready);
endinterface
`default_nettype wire

[src/mbsweep_out_if.sv]
// free-block record channel
`timescale 1ns / 1ps
`default_nettype none
interface mbsweep_out_if;
  logic                              valid;
  logic                              ready;
  logic                              is_free;
  logic [mbsweep_pkg::ADDR_W-1:0]    block_address;
  logic [mbsweep_pkg::ADDR_W-1:0]    next_link;
  logic                              last_of_item;
  logic                              end_of_region;
  logic [mbsweep_pkg::COUNT_W-1:0]   live_objects;
  logic [mbsweep_pkg::COUNT_W-1:0]   freed_objects;
  logic [mbsweep_pkg::BYTES_W-1:0]   live_bytes;
  logic [mbsweep_pkg::BYTES_W-1:0]   free_bytes;

  modport source (output valid, output is_free, output block_address, output next_link,
                  output last_of_item, output end_of_region, output live_objects,
                  output freed_objects, output live_bytes, output free_bytes,
                  input ready);
  modport sink   (input valid, input is_free, input block_address, input next_link,
                  input last_of_item, input end_of_region, input live_objects,
                  input freed_objects, input live_bytes, input free_bytes,
                  output ready);
endinterface
`default_nettype wire

[src/mbsweep_cfg.sv]
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none
module mbsweep_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mbsweep_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [mbsweep_pkg::PDATA_W-1:0]    pwdata,
  output logic      [mbsweep_pkg::PDATA_W-1:0]    prdata,
  output logic                                    pready,
  output mbsweep_pkg::cfg_t                       cfg
);
  import mbsweep_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_base     <= RST_REGION_BASE;
      cfg.object_size     <= RST_OBJECT_SIZE;
      cfg.slot_count      <= RST_SLOT_COUNT;
      cfg.mark_word_count <= RST_MARK_WORD_COUNT;
    end else if (wr) begin
      unique case (idx)
        REG_REGION_BASE:     cfg.region_base     <= pwdata[ADDR_W-1:0];
        REG_OBJECT_SIZE:     cfg.object_size     <= pwdata[SIZE_W-1:0];
        REG_SLOT_COUNT:      cfg.slot_count      <= pwdata[COUNT_W-1:0];
        REG_MARK_WORD_COUNT: cfg.mark_word_count <= pwdata[MWC_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REGION_BASE:     prdata = PDATA_W'(cfg.region_base);
      REG_OBJECT_SIZE:     prdata = PDATA_W'(cfg.object_size);
      REG_SLOT_COUNT:      prdata = PDATA_W'(cfg.slot_count);
      REG_MARK_WORD_COUNT: prdata = PDATA_W'(cfg.mark_word_count);
    endcase
  end

endmodule
`default_nettype wire

[src/mbsweep_front.sv]
// front end: accepts mark words, tracks the word index and classifies each word
`timescale 1ns / 1ps
`default_nettype none
module mbsweep_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mbsweep_pkg::cfg_t  cfg,
  mbsweep_in_if.sink              marks,
  input  wire logic               q_full,
  output logic                    push,
  output mbsweep_pkg::q_entry_t   entry
);
  import mbsweep_pkg::*;

  logic [WIDX_W-1:0]         word_index;
  logic [WIDX_W-1:0]         word_index_next;
  logic [COUNT_W-1:0]        n;
  logic [COUNT_W-1:0]        nm1;
  logic [WIDX_W-1:0]         final_word;
  logic [COUNT_W-1:0]        first_slot;
  logic [COUNT_W-1:0]        rem;
  logic [NV_W-1:0]           nvalid;
  logic                      word_ok;
  logic [MARK_WORD_BITS-1:0] word_eff;
  logic [MARK_WORD_BITS-1:0] valid_mask;
  logic [SIZE_W-1:0]         first16;

  assign marks.ready = ~q_full;
  assign push        = marks.valid & ~q_full;

  always_comb begin
    n          = (cfg.slot_count > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                        : cfg.slot_count;
    nm1        = n - COUNT_W'(1);
    final_word = (n == '0) ? '0 : nm1[SIZE_W-1:6];
    first16    = {word_index, 6'b0};
    first_slot = {1'b0, first16};
    rem        = n - first_slot;
    if (n <= first_slot) begin
      nvalid = '0;
    end else if (rem >= COUNT_W'(MARK_WORD_BITS)) begin
      nvalid = NV_W'(MARK_WORD_BITS);
    end else begin
      nvalid = rem[NV_W-1:0];
    end
    word_ok    = {1'b0, word_index} < cfg.mark_word_count;
    word_eff   = word_ok ? marks.mark_word : '0;
    // slots past the region's end are neither live nor free
    valid_mask = nvalid[NV_W-1] ? '1
                 : ((MARK_WORD_BITS'(1) << nvalid[NV_W-2:0]) - MARK_WORD_BITS'(1));
    entry.free_mask = ~word_eff & valid_mask;
    entry.nvalid    = nvalid;
    entry.closing   = word_index >= final_word;
    entry.off_start = {16'b0, first16} * {16'b0, cfg.object_size};
    word_index_next = entry.closing ? '0 : word_index + WIDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
    end else if (push) begin
      word_index <= word_index_next;
    end
  end

endmodule
`default_nettype wire

[src/mbsweep_queue.sv]
// two-entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module mbsweep_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire mbsweep_pkg::q_entry_t  push_entry,
  output logic                        full,
  input  wire logic                   pop,
  output logic                        head_valid,
  output mbsweep_pkg::q_entry_t       head_entry
);
  import mbsweep_pkg::*;

  q_entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      priority if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/mbsweep_back.sv]
// back end: walks one slot per cycle unless the output stalls, keeps totals and the list head, emits records
`timescale 1ns / 1ps
`default_nettype none
module mbsweep_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mbsweep_pkg::cfg_t      cfg,
  input  wire logic                   q_valid,
  input  wire mbsweep_pkg::q_entry_t  q_entry,
  output logic                        pop,
  mbsweep_out_if.source               records
);
  import mbsweep_pkg::*;

  bk_state_t                 state;
  bk_state_t                 state_next;
  logic [MARK_WORD_BITS-1:0] fm;
  logic [NV_W-1:0]           left;
  logic                      closing;
  logic [OFF_W-1:0]          off;
  logic [ADDR_W-1:0]         free_head;
  logic [COUNT_W-1:0]        live_count;
  logic [COUNT_W-1:0]        freed_count;
  logic [BYTES_W-1:0]        live_byte_total;
  logic [BYTES_W-1:0]        free_byte_total;

  logic                      can_emit;
  logic                      step;
  logic                      emit;
  logic                      sum;
  logic                      last_slot;
  logic                      clear_totals;
  logic [ADDR_W-1:0]         addr;
  logic [BYTES_W-1:0]        size32;
  logic                      rec_last;

  assign can_emit  = ~records.valid | records.ready;
  assign last_slot = left == NV_W'(1);
  assign addr      = cfg.region_base + {16'b0, off};
  assign size32    = {16'b0, cfg.object_size};
  // no free slot left in the word, and no summary to follow
  assign rec_last  = (fm[MARK_WORD_BITS-1:1] == '0) & (~closing | last_slot);

  always_comb begin
    pop  = 1'b0;
    step = 1'b0;
    emit = 1'b0;
    sum  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop = q_valid;
      end
      BK_RUN: begin
        step = ~fm[0] | can_emit;
        emit = fm[0] & can_emit;
      end
      BK_SUMMARY: begin
        sum = can_emit;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    clear_totals = (step & last_slot & closing & fm[0]) | sum;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = (q_entry.nvalid == '0) ? BK_SUMMARY : BK_RUN;
        end
      end
      BK_RUN: begin
        if (step && last_slot) begin
          state_next = (closing && !fm[0]) ? BK_SUMMARY : BK_IDLE;
        end
      end
      BK_SUMMARY: begin
        if (can_emit) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // word walk registers
  always_ff @(posedge clk) begin
    if (pop) begin
      fm      <= q_entry.free_mask;
      left    <= q_entry.nvalid;
      closing <= q_entry.closing;
      off     <= q_entry.off_start;
    end else if (step) begin
      fm   <= fm >> 1;
      left <= left - NV_W'(1);
      off  <= off + size32;
    end
  end

  // running totals and list head
  always_ff @(posedge clk) begin
    if (rst || clear_totals) begin
      free_head       <= '0;
      live_count      <= '0;
      freed_count     <= '0;
      live_byte_total <= '0;
      free_byte_total <= '0;
    end else if (step) begin
      if (fm[0]) begin
        free_head       <= addr;
        freed_count     <= freed_count + COUNT_W'(1);
        free_byte_total <= free_byte_total + size32;
      end else begin
        live_count      <= live_count + COUNT_W'(1);
        live_byte_total <= live_byte_total + size32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      records.valid <= 1'b0;
    end else if (emit || sum) begin
      records.valid <= 1'b1;
    end else if (records.ready) begin
      records.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      records.is_free       <= 1'b1;
      records.block_address <= addr;
      records.next_link     <= free_head;
      records.last_of_item  <= rec_last;
      records.end_of_region <= rec_last & closing;
      records.live_objects  <= live_count;
      records.freed_objects <= freed_count + COUNT_W'(1);
      records.live_bytes    <= live_byte_total;
      records.free_bytes    <= free_byte_total + size32;
    end else if (sum) begin
      records.is_free       <= 1'b0;
      records.block_address <= '0;
      records.next_link     <= free_head;
      records.last_of_item  <= 1'b1;
      records.end_of_region <= 1'b1;
      records.live_objects  <= live_count;
      records.freed_objects <= freed_count;
      records.live_bytes    <= live_byte_total;
      records.free_bytes    <= free_byte_total;
    end
  end

endmodule
`default_nettype wire

[src/mark_bitmap_sweeper.sv]
// Sweeps a region against a mark bitmap and emits a lifo free list, one slot per cycle
// while the record output is not stalled. The back end pops a mark word, walks its valid
// slots in turn and, for a closing word whose last valid slot is live, adds a summary record.
// A word reaches the output through the queue, the word walk registers and the output register.
// Front and back are parted by a 2-entry queue; results sit in an output register.
// Synchronous reset restores register defaults, clears totals, list head and word index.
`timescale 1ns / 1ps
`default_nettype none
module mark_bitmap_sweeper (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mbsweep_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [mbsweep_pkg::PDATA_W-1:0]    pwdata,
  output logic      [mbsweep_pkg::PDATA_W-1:0]    prdata,
  output logic                                    pready,
  mbsweep_in_if.sink                              marks,
  mbsweep_out_if.source                           records
);
  import mbsweep_pkg::*;

  cfg_t     cfg;
  q_entry_t push_entry;
  q_entry_t head_entry;
  logic     push;
  logic     q_full;
  logic     pop;
  logic     head_valid;

  mbsweep_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbsweep_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .marks  (marks),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  mbsweep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  mbsweep_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (head_valid),
    .q_entry (head_entry),
    .pop     (pop),
    .records (records)
  );

endmodule
`default_nettype wire

[verif/mark_bitmap_sweeper_tb.sv]
// self-checking bench for the mark bitmap sweeper: directed and random mark words
`timescale 1ns / 1ps
module mark_bitmap_sweeper_tb;
  import mbsweep_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 400;  // covers two queued full words plus one in the walk
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_WORDS  = 400;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic               is_free;
    logic [ADDR_W-1:0]  block_address;
    logic [ADDR_W-1:0]  next_link;
    logic               last_of_item;
    logic               end_of_region;
    logic [COUNT_W-1:0] live_objects;
    logic [COUNT_W-1:0] freed_objects;
    logic [BYTES_W-1:0] live_bytes;
    logic [BYTES_W-1:0] free_bytes;
  } free_rec_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mbsweep_in_if  marks_if();
  mbsweep_out_if records_if();

  mark_bitmap_sweeper u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .marks   (marks_if),
    .records (records_if)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // register mirror
  logic [ADDR_W-1:0]  cfg_base  = RST_REGION_BASE;
  logic [SIZE_W-1:0]  cfg_size  = RST_OBJECT_SIZE;
  logic [COUNT_W-1:0] cfg_slots = RST_SLOT_COUNT;
  logic [MWC_W-1:0]   cfg_words = RST_MARK_WORD_COUNT;

  // sweep state
  int unsigned        sweep_idx  = 0;
  logic [ADDR_W-1:0]  list_head  = '0;
  logic [COUNT_W-1:0] live_cnt   = '0;
  logic [COUNT_W-1:0] freed_cnt  = '0;
  logic [BYTES_W-1:0] live_total = '0;
  logic [BYTES_W-1:0] free_total = '0;

  free_rec_t   expected_recs[$];
  logic [63:0] mark_words_q[$];

  int unsigned words_pushed   = 0;
  int unsigned words_taken    = 0;
  int unsigned recs_checked   = 0;
  int unsigned regions_closed = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_pct       = 16;
  int unsigned cycle_count    = 0;
  logic        in_taken;

  function automatic int unsigned clamp_slots(logic [COUNT_W-1:0] slots);
    return (slots > MAX_SLOTS) ? MAX_SLOTS : 32'(slots);
  endfunction

  // walks one mark word and queues the free-block records it gives
  function automatic void sweep_word(logic [63:0] mark);
    int unsigned       n;
    int unsigned       last_idx;
    int unsigned       slot;
    int unsigned       first;
    logic              closing;
    logic              last_free;
    logic [63:0]       bits;
    logic [63:0]       offset;
    logic [ADDR_W-1:0] addr;
    free_rec_t         rec;
    first = expected_recs.size();
    n = clamp_slots(cfg_slots);
    last_idx = (n != 0) ? (n - 1) / MARK_WORD_BITS : 0;
    closing = (sweep_idx >= last_idx);
    bits = (sweep_idx < cfg_words) ? mark : '0;
    last_free = 1'b0;
    for (int i = 0; i < MARK_WORD_BITS; i++) begin
      slot = sweep_idx * MARK_WORD_BITS + i;
      if (slot >= n) break;
      if (bits[i]) begin
        live_cnt = live_cnt + 1'b1;
        live_total = live_total + BYTES_W'(cfg_size);
        last_free = 1'b0;
      end else begin
        offset = 64'(slot) * 64'(cfg_size);
        addr = ADDR_W'(64'(cfg_base) + offset);
        freed_cnt = freed_cnt + 1'b1;
        free_total = free_total + BYTES_W'(cfg_size);
        rec = '{is_free: 1'b1, block_address: addr, next_link: list_head,
                last_of_item: 1'b0, end_of_region: 1'b0,
                live_objects: live_cnt, freed_objects: freed_cnt,
                live_bytes: live_total, free_bytes: free_total};
        expected_recs = {expected_recs, rec};
        list_head = addr;
        last_free = 1'b1;
      end
    end
    // closing word whose last slot is live gets a summary record
    if (closing && !last_free) begin
      rec = '{is_free: 1'b0, block_address: '0, next_link: list_head,
              last_of_item: 1'b0, end_of_region: 1'b0,
              live_objects: live_cnt, freed_objects: freed_cnt,
              live_bytes: live_total, free_bytes: free_total};
      expected_recs = {expected_recs, rec};
    end
    if (expected_recs.size() > first) begin
      rec = expected_recs[$];
      rec.last_of_item = 1'b1;
      rec.end_of_region = closing;
      expected_recs[expected_recs.size() - 1] = rec;
    end
    if (closing) begin
      regions_closed++;
      sweep_idx  = 0;
      list_head  = '0;
      live_cnt   = '0;
      freed_cnt  = '0;
      live_total = '0;
      free_total = '0;
    end else begin
      sweep_idx++;
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  function automatic logic [63:0] pick_mark();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(4))
      0: w = '1;
      1: w = '0;
      2: w = ~((64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63)));
      3: w = w & {$urandom, $urandom} & {$urandom, $urandom};
      default: ;
    endcase
    return w;
  endfunction

  function automatic void push_word(logic [63:0] w);
    mark_words_q = {mark_words_q, w};
    words_pushed++;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_REGION_BASE:     cfg_base  = value[ADDR_W-1:0];
      REG_OBJECT_SIZE:     cfg_size  = value[SIZE_W-1:0];
      REG_SLOT_COUNT:      cfg_slots = value[COUNT_W-1:0];
      REG_MARK_WORD_COUNT: cfg_words = value[MWC_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // sender holds off until every record is back, then the back end runs dry
  task automatic settle();
    while (words_taken != words_pushed || expected_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      marks_if.valid <= 1'b0;
    end else if (!marks_if.valid || in_taken) begin
      if (mark_words_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        marks_if.valid     <= 1'b1;
        marks_if.mark_word <= mark_words_q.pop_front();
      end else begin
        marks_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      records_if.ready <= 1'b0;
    end else begin
      records_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    free_rec_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= marks_if.valid && marks_if.ready;
      if (marks_if.valid && marks_if.ready) begin
        sweep_word(marks_if.mark_word);
        words_taken++;
      end
      if (records_if.valid && records_if.ready) begin
        if (expected_recs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) $error("record arrived with none expected");
        end else begin
          want = expected_recs.pop_front();
          recs_checked++;
          check_field("is_free", 64'(want.is_free), 64'(records_if.is_free));
          check_field("block_address", 64'(want.block_address),
                      64'(records_if.block_address));
          check_field("next_link", 64'(want.next_link), 64'(records_if.next_link));
          check_field("last_of_item", 64'(want.last_of_item),
                      64'(records_if.last_of_item));
          check_field("end_of_region", 64'(want.end_of_region),
                      64'(records_if.end_of_region));
          check_field("live_objects", 64'(want.live_objects),
                      64'(records_if.live_objects));
          check_field("freed_objects", 64'(want.freed_objects),
                      64'(records_if.freed_objects));
          check_field("live_bytes", 64'(want.live_bytes), 64'(records_if.live_bytes));
          check_field("free_bytes", 64'(want.free_bytes), 64'(records_if.free_bytes));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timed out with %0d records outstanding", expected_recs.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned       phase;
    int unsigned       random_words;
    int unsigned       n;
    int unsigned       last_idx;
    int unsigned       burst;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [COUNT_W-1:0] slots;
    logic [MWC_W-1:0]  valid_words;
    logic [63:0]       r64;

    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    marks_if.valid     = 1'b0;
    marks_if.mark_word = '0;
    records_if.ready   = 1'b0;
    phase              = 0;
    random_words       = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // 100-slot region, two words each
    reg_write(REG_REGION_BASE, 64'h1000);
    reg_write(REG_OBJECT_SIZE, 64'd8);
    reg_write(REG_SLOT_COUNT, 64'd100);
    reg_write(REG_MARK_WORD_COUNT, 64'd1024);
    push_word('1);
    push_word('0);
    push_word('0);
    push_word(64'h0000_0008_0000_0000);  // last slot live closes with a summary
    push_word(64'h5555_5555_5555_5555);
    push_word(64'hAAAA_AAAA_AAAA_AAAA);
    settle();

    // empty region, zero stride
    reg_write(REG_REGION_BASE, 64'd0);
    reg_write(REG_OBJECT_SIZE, 64'd0);
    reg_write(REG_SLOT_COUNT, 64'd0);
    push_word(64'h0123_4567_89AB_CDEF);
    push_word('1);
    settle();

    // single slot: live, then freed at address zero
    reg_write(REG_SLOT_COUNT, 64'd1);
    push_word(64'h1);
    push_word(64'hFFFF_FFFF_FFFF_FFFE);
    settle();

    // no valid mark words, addresses wrap past the top
    reg_write(REG_REGION_BASE, 64'hFFFF_FFFF_FC00);
    reg_write(REG_OBJECT_SIZE, 64'd65535);
    reg_write(REG_SLOT_COUNT, 64'd200);
    reg_write(REG_MARK_WORD_COUNT, 64'd0);
    repeat (4) push_word(pick_mark());
    settle();

    // saturated slot count, then the region shrinks under the word index
    reg_write(REG_MARK_WORD_COUNT, 64'd2047);
    reg_write(REG_SLOT_COUNT, 64'd131071);
    repeat (3) push_word(pick_mark());
    settle();
    reg_write(REG_SLOT_COUNT, 64'd64);
    push_word(pick_mark());
    settle();
    reg_write(REG_SLOT_COUNT, 64'd65536);
    reg_write(REG_MARK_WORD_COUNT, 64'd1024);
    repeat (2) push_word(pick_mark());
    settle();

    while (random_words < RANDOM_WORDS) begin
      phase++;
      idle_pct = (phase == 6) ? 0 : 16;
      r64 = {$urandom, $urandom};
      case ($urandom_range(3))
        0: base = '0;
        1: base = r64[ADDR_W-1:0];
        2: base = '1 - ADDR_W'($urandom_range(100000));
        default: base = ADDR_W'($urandom_range(65535));
      endcase
      case ($urandom_range(9))
        0: size = 16'd0;
        1: size = 16'd1;
        2: size = 16'hFFFF;
        3: size = SIZE_W'($urandom_range(65535));
        default: size = SIZE_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(19))
        0: slots = '0;
        1: slots = COUNT_W'(MAX_SLOTS);
        2: slots = COUNT_W'($urandom_range(MAX_SLOTS + 1, 131071));
        3, 4: slots = COUNT_W'($urandom_range(1, 64));
        default: slots = COUNT_W'($urandom_range(1, 400));
      endcase
      n = clamp_slots(slots);
      last_idx = (n != 0) ? (n - 1) / MARK_WORD_BITS : 0;
      case ($urandom_range(5))
        0: valid_words = 11'd2047;
        1: valid_words = '0;
        default: valid_words = MWC_W'($urandom_range(0, last_idx + 2));
      endcase
      if ($urandom_range(3) != 0) reg_write(REG_REGION_BASE, 64'(base));
      if ($urandom_range(3) != 0) reg_write(REG_OBJECT_SIZE, 64'(size));
      if ($urandom_range(3) != 0) reg_write(REG_SLOT_COUNT, 64'(slots));
      if ($urandom_range(3) != 0) reg_write(REG_MARK_WORD_COUNT, 64'(valid_words));
      n = clamp_slots(cfg_slots);
      last_idx = (n != 0) ? (n - 1) / MARK_WORD_BITS : 0;
      if (phase == 6) burst = 40;
      else if (n >= MAX_SLOTS) burst = $urandom_range(2, 6);
      else burst = $urandom_range(1, 2 * last_idx + 3);
      if (burst > 40) burst = 40;
      repeat (burst) push_word(pick_mark());
      random_words += burst;
      settle();
    end

    $display("swept %0d mark words into %0d checked records, %0d regions closed",
             words_taken, recs_checked, regions_closed);
    $display("%0d register writes over %0d random settings, %0d mismatches",
             reg_writes, phase, mismatches);
    if (mismatches == 0 && expected_recs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
